@@ hdl/l2d_pkg.sv @@
// Shared constants, widths and helpers for the 2-D Legendre basis evaluator.
// Used by l2d_lane and legendre_2d_basis_eval_unit; no dependencies.
package l2d_pkg;

  localparam int COORD_W     = 18;
  localparam int IDX_W       = 5;
  localparam int DEG_W       = 3;
  localparam int PW          = 40;   // Q.32 working width
  localparam int PA_W        = 32;   // polynomial value, Q.24
  localparam int CW          = 26;   // Q.24 coefficient width
  localparam int TERM_COUNT  = 21;
  localparam int LANE_STAGES = 8;
  localparam int NSTG        = LANE_STAGES + 2;

  localparam logic signed [CW-1:0] C_3_5_Q24  = 26'sd10066330;
  localparam logic signed [CW-1:0] C_6_7_Q24  = 26'sd14380471;
  localparam logic signed [CW-1:0] C_10_9_Q24 = 26'sd18641351;
  localparam logic signed [CW-1:0] C_5_21_Q24 = 26'sd3994575;

  localparam logic signed [PW-1:0] K_THIRD_Q32 = 40'sd1431655765;
  localparam logic signed [PW-1:0] K_3_35_Q32  = 40'sd368140054;
  localparam logic signed [PW-1:0] ONE_Q32     = 40'sh01_0000_0000;

  localparam logic signed [63:0] VAL_MAX = 64'sd131071;
  localparam logic signed [63:0] VAL_MIN = -64'sd131072;

  localparam logic [DEG_W-1:0] DEG_X [TERM_COUNT] = '{
    3'd0, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2, 3'd1, 3'd0, 3'd4,
    3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
  };
  localparam logic [DEG_W-1:0] DEG_Y [TERM_COUNT] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd3, 3'd0,
    3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
  };

  // round half up, then arithmetic shift right by s
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

endpackage

@@ hdl/l2d_lane.sv @@
// One coordinate lane: pipelined monic Legendre polynomial of degree 0..5.
// Eight register stages, Q.16 in, Q.24 out; depends on l2d_pkg.
module l2d_lane (
  input  logic                                  clk,
  input  logic [l2d_pkg::LANE_STAGES-1:0]       en,
  input  logic signed [l2d_pkg::COORD_W-1:0]    p_in,
  input  logic [l2d_pkg::DEG_W-1:0]             deg_in,
  output logic signed [l2d_pkg::PA_W-1:0]       pa_out
);
  import l2d_pkg::*;

  // stage 1
  logic signed [COORD_W-1:0] x1_r;
  logic [DEG_W-1:0]          d1_r;
  logic signed [35:0]        p2_1_r;
  logic signed [43:0]        k35_1_r, k521_1_r;
  // stage 2
  logic signed [COORD_W-1:0] x2_r;
  logic [DEG_W-1:0]          d2_r;
  logic signed [35:0]        p2_2_r;
  logic signed [53:0]        p3w_2_r;
  logic signed [61:0]        k67_2_r;
  logic signed [PW-1:0]      t35_2_r, t521_2_r;
  // stage 3
  logic signed [COORD_W-1:0] x3_r;
  logic [DEG_W-1:0]          d3_r;
  logic signed [35:0]        p2_3_r;
  logic signed [36:0]        p3_3_r;
  logic signed [PW-1:0]      t35_3_r, t521_3_r, t67_3_r;
  // stage 4
  logic signed [COORD_W-1:0] x4_r;
  logic [DEG_W-1:0]          d4_r;
  logic signed [54:0]        p4w_4_r;
  logic signed [62:0]        k109_4_r;
  logic signed [PW-1:0]      poly2_4_r, poly3_4_r, c4_4_r, t521_4_r;
  // stage 5
  logic signed [COORD_W-1:0] x5_r;
  logic [DEG_W-1:0]          d5_r;
  logic signed [37:0]        p4_5_r;
  logic signed [PW-1:0]      poly2_5_r, poly3_5_r, c4_5_r, part5_5_r;
  // stages 6 to 8
  logic signed [55:0]        p5w_6_r;
  logic signed [PW-1:0]      r_6_r, r_7_r;
  logic                      is5_6_r;
  logic signed [PA_W-1:0]    pa_8_r;

  logic signed [63:0] t35_nxt, t521_nxt, p3_nxt, t67_nxt, p4_nxt, t109_nxt;
  logic signed [63:0] p5_nxt, pa_nxt;
  logic signed [PW-1:0] r_6_nxt;

  assign t35_nxt  = rnd(64'(k35_1_r), 8);
  assign t521_nxt = rnd(64'(k521_1_r), 8);
  assign p3_nxt   = rnd(64'(p3w_2_r), 16);
  assign t67_nxt  = rnd(64'(k67_2_r), 24);
  assign p4_nxt   = rnd(64'(p4w_4_r), 16);
  assign t109_nxt = rnd(64'(k109_4_r), 24);
  assign p5_nxt   = rnd(64'(p5w_6_r), 16);
  assign pa_nxt   = rnd(64'(r_7_r), 8);

  always_comb begin
    case (d5_r)
      3'd0:    r_6_nxt = ONE_Q32;
      3'd1:    r_6_nxt = PW'(x5_r) <<< 16;
      3'd2:    r_6_nxt = poly2_5_r;
      3'd3:    r_6_nxt = poly3_5_r;
      3'd4:    r_6_nxt = PW'(p4_5_r) + c4_5_r;
      default: r_6_nxt = part5_5_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1_r     <= p_in;
      d1_r     <= deg_in;
      p2_1_r   <= p_in * p_in;
      k35_1_r  <= C_3_5_Q24 * p_in;
      k521_1_r <= C_5_21_Q24 * p_in;
    end
    if (en[1]) begin
      x2_r     <= x1_r;
      d2_r     <= d1_r;
      p2_2_r   <= p2_1_r;
      p3w_2_r  <= p2_1_r * x1_r;
      k67_2_r  <= C_6_7_Q24 * p2_1_r;
      t35_2_r  <= t35_nxt[PW-1:0];
      t521_2_r <= t521_nxt[PW-1:0];
    end
    if (en[2]) begin
      x3_r     <= x2_r;
      d3_r     <= d2_r;
      p2_3_r   <= p2_2_r;
      p3_3_r   <= p3_nxt[36:0];
      t35_3_r  <= t35_2_r;
      t521_3_r <= t521_2_r;
      t67_3_r  <= t67_nxt[PW-1:0];
    end
    if (en[3]) begin
      x4_r      <= x3_r;
      d4_r      <= d3_r;
      p4w_4_r   <= p3_3_r * x3_r;
      k109_4_r  <= C_10_9_Q24 * p3_3_r;
      poly2_4_r <= PW'(p2_3_r) - K_THIRD_Q32;
      poly3_4_r <= PW'(p3_3_r) - t35_3_r;
      c4_4_r    <= K_3_35_Q32 - t67_3_r;
      t521_4_r  <= t521_3_r;
    end
    if (en[4]) begin
      x5_r      <= x4_r;
      d5_r      <= d4_r;
      p4_5_r    <= p4_nxt[37:0];
      poly2_5_r <= poly2_4_r;
      poly3_5_r <= poly3_4_r;
      c4_5_r    <= c4_4_r;
      part5_5_r <= t521_4_r - t109_nxt[PW-1:0];
    end
    if (en[5]) begin
      p5w_6_r <= p4_5_r * x5_r;
      r_6_r   <= r_6_nxt;
      is5_6_r <= (d5_r == 3'd5);
    end
    if (en[6]) begin
      r_7_r <= is5_6_r ? r_6_r + p5_nxt[PW-1:0] : r_6_r;
    end
    if (en[7]) begin
      pa_8_r <= pa_nxt[PA_W-1:0];
    end
  end

  assign pa_out = pa_8_r;

endmodule

@@ hdl/legendre_2d_basis_eval_unit.sv @@
// Top level of the 2-D monic Legendre basis evaluator, total degree up to five.
// Depends on l2d_pkg and l2d_lane.

// Takes one (term index, x, y) transaction per clock while in_ready is high and
// returns Pa(x)*Pb(y) in signed Q2.16, saturated. The result is offered once it
// has passed through every register stage. Two lanes of eight stages build the
// x and y polynomials from a chain of pipelined multipliers (x^2, x^3, x^4,
// x^5 and the coefficient products); one stage forms the product and a last
// stage rounds, saturates and holds the result. Each stage moves on when it is
// empty or its successor moves, so bubbles are squeezed out and input is taken
// while a result waits.
// An index above 20 gives a zero value with index_ok low.
module legendre_2d_basis_eval_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [l2d_pkg::IDX_W-1:0]            in_term_index,
  input  logic signed [l2d_pkg::COORD_W-1:0]   in_x_pos,
  input  logic signed [l2d_pkg::COORD_W-1:0]   in_y_pos,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [l2d_pkg::COORD_W-1:0]   out_term_value,
  output logic                                 out_index_ok
);
  import l2d_pkg::*;

  logic                   vld_r [1:NSTG];
  logic                   ok_r  [1:NSTG];
  logic                   rdy   [1:NSTG+1];
  logic [LANE_STAGES-1:0] lane_en;
  logic                   idx_ok;
  logic [DEG_W-1:0]       dx, dy;
  logic signed [PA_W-1:0] pa_x, pa_y;
  logic signed [63:0]     prod_r;
  logic signed [63:0]     val_nxt;
  logic signed [COORD_W-1:0] term_r, term_nxt;

  assign idx_ok = (in_term_index < IDX_W'(TERM_COUNT));
  assign dx     = idx_ok ? DEG_X[in_term_index] : '0;
  assign dy     = idx_ok ? DEG_Y[in_term_index] : '0;

  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    for (int k = 0; k < LANE_STAGES; k++) begin
      lane_en[k] = rdy[k+1];
    end
  end

  assign in_ready = rdy[1];

  l2d_lane u_lane_x (
    .clk    (clk),
    .en     (lane_en),
    .p_in   (in_x_pos),
    .deg_in (dx),
    .pa_out (pa_x)
  );

  l2d_lane u_lane_y (
    .clk    (clk),
    .en     (lane_en),
    .p_in   (in_y_pos),
    .deg_in (dy),
    .pa_out (pa_y)
  );

  assign val_nxt = rnd(prod_r, 32);

  always_comb begin
    if (!ok_r[NSTG-1]) begin
      term_nxt = '0;
    end else if (val_nxt > VAL_MAX) begin
      term_nxt = VAL_MAX[COORD_W-1:0];
    end else if (val_nxt < VAL_MIN) begin
      term_nxt = VAL_MIN[COORD_W-1:0];
    end else begin
      term_nxt = val_nxt[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ok_r[1] <= idx_ok;
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k]) begin
        ok_r[k] <= ok_r[k-1];
      end
    end
    if (rdy[NSTG-1]) begin
      prod_r <= pa_x * pa_y;
    end
    if (rdy[NSTG]) begin
      term_r <= term_nxt;
    end
  end

  assign out_valid      = vld_r[NSTG];
  assign out_term_value = term_r;
  assign out_index_ok   = ok_r[NSTG];

  a_bad_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_ok |-> out_term_value == '0)
    else $error("invalid index transaction with non-zero value");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted transaction not held in first stage");

endmodule
